[rtl/motor_command_ramp_top_macros.svh]
// ============================================================================
// motor_command_ramp assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ============================================================================
`ifndef MOTOR_COMMAND_RAMP_TOP_MACROS_SVH
`define MOTOR_COMMAND_RAMP_TOP_MACROS_SVH

// same-cycle implication
`define MCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mcr_pkg.sv]
// ============================================================================
// mcr_pkg
// Widths, constants and controller/datapath interface types for the ramp.
// ============================================================================
`timescale 1ns / 1ps

package mcr_pkg;

    localparam int TIME_BITS = 32;   // time stamp arithmetic width
    localparam int IN_TIME_W = 32;   // time_ms field width
    localparam int CMD_W     = 9;
    localparam int MAG_W     = 8;
    localparam int DIFF_W    = 10;
    localparam int STEP_W    = 10;
    localparam int DT_W      = 9;
    localparam int DUR_W     = 16;
    localparam int INC_W     = 20;
    localparam int QUO_W     = 9;    // |diff| <= 510
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DT_W-1:0] ELAPSED_MAX = 9'd511;
    localparam logic signed [CMD_W-1:0] CMD_MIN  = -9'sd255;
    localparam logic signed [CMD_W-1:0] CMD_NEG_FULL = -9'sd256;
    localparam logic signed [STEP_W-1:0] STEP_NEG_ONE = -10'sd1;
    localparam logic signed [STEP_W-1:0] STEP_POS_ONE = 10'sd1;
    localparam logic [DUR_W-1:0] DUR_RESET = 16'd100;

    // register indexes
    localparam logic REG_RAMP_DUR = 1'b0;
    localparam logic REG_STOP_DUR = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the input beat
        logic eval;      // elapsed time, last time, divider setup
        logic div_step;  // one restoring division step
        logic wr_step;   // signed step from quotient
        logic mul;       // step * elapsed
        logic apply;     // advance or snap the command
        logic emit;      // load the result register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic same_cmd;
        logic new_tgt;
        logic dt_zero;
        logic div_last;
    } t_dp_status;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EVAL  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_STEP  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_APPLY = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

endpackage

[rtl/mcr_datapath.sv]
// ============================================================================
// mcr_datapath
// Ramp state, serial divider, step multiplier and output result register.
// ============================================================================
`timescale 1ns / 1ps
`include "motor_command_ramp_top_macros.svh"

module mcr_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mcr_pkg::t_ctrl_cmd                    i_cmd,
    output mcr_pkg::t_dp_status                   o_status,
    input  logic                                  i_mode,
    input  logic signed [mcr_pkg::CMD_W-1:0]      i_target,
    input  logic [mcr_pkg::IN_TIME_W-1:0]         i_time_ms,
    input  logic [mcr_pkg::DUR_W-1:0]             i_ramp_dur,
    input  logic [mcr_pkg::DUR_W-1:0]             i_stop_dur,
    output logic [mcr_pkg::MAG_W-1:0]             o_forward_duty,
    output logic [mcr_pkg::MAG_W-1:0]             o_reverse_duty,
    output logic signed [mcr_pkg::CMD_W-1:0]      o_command,
    output logic                                  o_updated
);

    // persistent ramp state
    logic signed [mcr_pkg::CMD_W-1:0]  r_cmd, r_last_tgt;
    logic signed [mcr_pkg::STEP_W-1:0] r_step;
    logic [mcr_pkg::TIME_BITS-1:0]     r_last_time;

    // per-beat working registers
    logic signed [mcr_pkg::CMD_W-1:0]  r_tgt;
    logic [mcr_pkg::DUR_W-1:0]         r_dur;
    logic [mcr_pkg::TIME_BITS-1:0]     r_now;
    logic [mcr_pkg::DT_W-1:0]          r_dt;
    logic                              r_neg;
    logic [mcr_pkg::QUO_W-1:0]         r_dvd;
    logic [mcr_pkg::DUR_W-1:0]         r_rem;
    logic [mcr_pkg::CNT_W-1:0]         r_cnt;
    logic signed [mcr_pkg::INC_W-1:0]  r_inc;
    logic                              r_upd;

    // result register
    logic [mcr_pkg::MAG_W-1:0]         r_fwd, r_rev;
    logic signed [mcr_pkg::CMD_W-1:0]  r_out_cmd;
    logic                              r_out_upd;

    logic signed [mcr_pkg::CMD_W-1:0]  tgt_sat;
    logic [mcr_pkg::DUR_W-1:0]         dur_sel;
    logic [mcr_pkg::TIME_BITS+mcr_pkg::IN_TIME_W-1:0] time_ext;
    logic [mcr_pkg::TIME_BITS-1:0]     time_diff;
    logic [mcr_pkg::DT_W-1:0]          dt_sat;
    logic signed [mcr_pkg::DIFF_W-1:0] diff;
    logic [mcr_pkg::DIFF_W-1:0]        diff_abs;
    logic [mcr_pkg::DUR_W:0]           shifted, trial;
    logic                              ge;
    logic signed [mcr_pkg::STEP_W-1:0] quo_signed, step_val;
    logic signed [mcr_pkg::INC_W-1:0]  prod, inc_abs, sum;
    logic signed [mcr_pkg::CMD_W-1:0]  next_cmd;

    // input conditioning
    always_comb begin
        if (!i_mode) begin
            tgt_sat = '0;
            dur_sel = i_stop_dur;
        end else begin
            tgt_sat = (i_target == mcr_pkg::CMD_NEG_FULL) ? mcr_pkg::CMD_MIN : i_target;
            dur_sel = i_ramp_dur;
        end
        if (dur_sel == '0) begin
            dur_sel = mcr_pkg::DUR_W'(1);
        end
        time_ext = {mcr_pkg::TIME_BITS'(0), i_time_ms};
    end

    // elapsed time and difference
    always_comb begin
        time_diff = r_now - r_last_time;
        dt_sat    = (|time_diff[mcr_pkg::TIME_BITS-1:mcr_pkg::DT_W]) ? mcr_pkg::ELAPSED_MAX
                                                                    : time_diff[mcr_pkg::DT_W-1:0];
        diff      = mcr_pkg::DIFF_W'(r_tgt) - mcr_pkg::DIFF_W'(r_cmd);
        diff_abs  = diff[mcr_pkg::DIFF_W-1] ? mcr_pkg::DIFF_W'(-diff) : mcr_pkg::DIFF_W'(diff);
    end

    // restoring divider step
    always_comb begin
        shifted = {r_rem, r_dvd[mcr_pkg::QUO_W-1]};
        trial   = shifted - {1'b0, r_dur};
        ge      = shifted >= {1'b0, r_dur};
    end

    // signed step, minimum magnitude one
    always_comb begin
        quo_signed = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
        if (r_dvd == '0) begin
            step_val = r_neg ? mcr_pkg::STEP_NEG_ONE : mcr_pkg::STEP_POS_ONE;
        end else begin
            step_val = quo_signed;
        end
    end

    // advance or snap
    always_comb begin
        prod    = r_step * $signed({1'b0, r_dt});
        inc_abs = r_inc[mcr_pkg::INC_W-1] ? -r_inc : r_inc;
        sum     = mcr_pkg::INC_W'(r_cmd) + r_inc;
        if (inc_abs < $signed(mcr_pkg::INC_W'(diff_abs))) begin
            next_cmd = sum[mcr_pkg::CMD_W-1:0];
        end else begin
            next_cmd = r_tgt;
        end
    end

    // ramp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= '0;
            r_last_tgt  <= '0;
            r_step      <= '0;
            r_last_time <= '0;
        end else begin
            if (i_cmd.eval) begin
                r_last_time <= r_now;
                if (o_status.new_tgt) begin
                    r_last_tgt <= r_tgt;
                end
            end
            if (i_cmd.wr_step) begin
                r_step <= step_val;
            end
            if (i_cmd.apply) begin
                r_cmd <= next_cmd;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tgt <= tgt_sat;
            r_dur <= dur_sel;
            r_now <= time_ext[mcr_pkg::TIME_BITS-1:0];
            r_upd <= 1'b0;
        end
        if (i_cmd.eval) begin
            r_dt  <= o_status.new_tgt ? mcr_pkg::DT_W'(1) : dt_sat;
            r_neg <= diff[mcr_pkg::DIFF_W-1];
            r_dvd <= diff_abs[mcr_pkg::QUO_W-1:0];
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? trial[mcr_pkg::DUR_W-1:0] : shifted[mcr_pkg::DUR_W-1:0];
            r_dvd <= {r_dvd[mcr_pkg::QUO_W-2:0], ge};
            r_cnt <= r_cnt + mcr_pkg::CNT_W'(1);
        end
        if (i_cmd.mul) begin
            r_inc <= prod;
        end
        if (i_cmd.apply) begin
            r_upd <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_fwd     <= r_cmd[mcr_pkg::CMD_W-1] ? '0 : r_cmd[mcr_pkg::MAG_W-1:0];
            r_rev     <= r_cmd[mcr_pkg::CMD_W-1] ? mcr_pkg::MAG_W'(-r_cmd) : '0;
            r_out_cmd <= r_cmd;
            r_out_upd <= r_upd;
        end
    end

    assign o_status.same_cmd = (r_tgt == r_cmd);
    assign o_status.new_tgt  = (r_tgt != r_last_tgt);
    assign o_status.dt_zero  = (r_dt == '0);
    assign o_status.div_last = (r_cnt == mcr_pkg::CNT_W'(mcr_pkg::DIV_STEPS - 1));

    assign o_forward_duty = r_fwd;
    assign o_reverse_duty = r_rev;
    assign o_command      = r_out_cmd;
    assign o_updated      = r_out_upd;

    `MCR_ASSERT_NOW(a_cmd_range, 1'b1, r_cmd != mcr_pkg::CMD_NEG_FULL, "command left range")
    `MCR_ASSERT_NEXT(a_step_nonzero, i_cmd.wr_step, r_step != '0, "zero step written")
    `MCR_ASSERT_NEXT(a_apply_marks, i_cmd.apply, r_upd, "apply did not mark update")

endmodule

[rtl/mcr_ctrl.sv]
// ============================================================================
// mcr_ctrl
// Sequencer for one beat: evaluate, divide, multiply, apply, emit.
// ============================================================================
`timescale 1ns / 1ps
`include "motor_command_ramp_top_macros.svh"

module mcr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    output logic                 o_s_ready,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    input  mcr_pkg::t_dp_status  i_status,
    output mcr_pkg::t_ctrl_cmd   o_cmd
);

    mcr_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    assign out_free  = !r_out_valid || i_m_ready;
    assign o_s_ready = (r_state == mcr_pkg::S_IDLE);
    assign o_m_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            mcr_pkg::S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mcr_pkg::S_EVAL;
                end
            end
            mcr_pkg::S_EVAL: begin
                if (i_status.same_cmd) begin
                    n_state = mcr_pkg::S_EMIT;
                end else begin
                    o_cmd.eval = 1'b1;
                    n_state    = i_status.new_tgt ? mcr_pkg::S_DIV : mcr_pkg::S_CHECK;
                end
            end
            mcr_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = mcr_pkg::S_STEP;
                end
            end
            mcr_pkg::S_STEP: begin
                o_cmd.wr_step = 1'b1;
                n_state       = mcr_pkg::S_CHECK;
            end
            mcr_pkg::S_CHECK: begin
                if (i_status.dt_zero) begin
                    n_state = mcr_pkg::S_EMIT;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = mcr_pkg::S_APPLY;
                end
            end
            mcr_pkg::S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = mcr_pkg::S_EMIT;
            end
            mcr_pkg::S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = mcr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mcr_pkg::S_IDLE;
            end
        endcase
    end

    // result beat valid
    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `MCR_ASSERT_NEXT(a_accept_eval, i_s_valid && o_s_ready, r_state == mcr_pkg::S_EVAL,
                     "accepted beat not evaluated")
    `MCR_ASSERT_NEXT(a_div_done, (r_state == mcr_pkg::S_DIV) && i_status.div_last,
                     r_state == mcr_pkg::S_STEP, "divider overran")
    `MCR_ASSERT_NEXT(a_emit_wait, (r_state == mcr_pkg::S_EMIT) && r_out_valid && !i_m_ready,
                     (r_state == mcr_pkg::S_EMIT) && r_out_valid, "result overwritten")

endmodule

[rtl/motor_command_ramp_top.sv]
// ============================================================================
// motor_command_ramp_top
// Slew-limited signed motor command with forward/reverse PWM duty split.
// ============================================================================
//  channel  | dir | content
//  s_axis   | in  | tdata: target[8:0], time_ms[40:9]; tuser: mode
//  m_axis   | out | tdata: fwd[7:0], rev[15:8], command[24:16], updated[25]
//  apb      | in  | 0x0 ramp_duration, 0x4 stop_duration (16 bit)
//
//  One beat at a time; a new target takes longest from accept to result, as only
//  it runs the nine-step serial divider.
//  s_axis_tready is high only while the sequencer is idle.
//  A waiting result beat stalls the sequencer at its final step only.
//  Reset is synchronous, active low; durations reset to 100.
`timescale 1ns / 1ps

module motor_command_ramp_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // target[8:0], time_ms[40:9], zero pad
    input  logic        s_axis_tuser,   // mode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // forward_duty[7:0], reverse_duty[15:8],
                                        // command[24:16], updated[25], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [mcr_pkg::DUR_W-1:0] r_ramp_dur, r_stop_dur;
    logic                      wr_en;

    mcr_pkg::t_ctrl_cmd  cmd;
    mcr_pkg::t_dp_status status;

    logic [mcr_pkg::MAG_W-1:0]        fwd, rev;
    logic signed [mcr_pkg::CMD_W-1:0] cmd_out;
    logic                             upd;

    // configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_dur <= mcr_pkg::DUR_RESET;
            r_stop_dur <= mcr_pkg::DUR_RESET;
        end else if (wr_en) begin
            if (paddr[2] == mcr_pkg::REG_RAMP_DUR) begin
                r_ramp_dur <= pwdata[mcr_pkg::DUR_W-1:0];
            end else begin
                r_stop_dur <= pwdata[mcr_pkg::DUR_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == mcr_pkg::REG_STOP_DUR) ? {16'd0, r_stop_dur}
                                                        : {16'd0, r_ramp_dur};

    mcr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    mcr_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (s_axis_tuser),
        .i_target       ($signed(s_axis_tdata[8:0])),
        .i_time_ms      (s_axis_tdata[40:9]),
        .i_ramp_dur     (r_ramp_dur),
        .i_stop_dur     (r_stop_dur),
        .o_forward_duty (fwd),
        .o_reverse_duty (rev),
        .o_command      (cmd_out),
        .o_updated      (upd)
    );

    assign m_axis_tdata = {6'd0, upd, cmd_out, rev, fwd};

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for motor_command_ramp_top. Speed updates are streamed
// in with random bursts and gaps while the result side stalls on its own
// pattern. Every accepted update runs through an in-bench ramp predictor and
// each result beat is compared field by field against the oldest prediction.
// The run walks several duration settings written over APB between phases.
// ============================================================================

module tb;

    localparam logic       MODE_STOP       = 1'b0;
    localparam logic       MODE_SPEED      = 1'b1;
    localparam logic [2:0] ADDR_RAMP_DUR   = {mcr_pkg::REG_RAMP_DUR, 2'b00};
    localparam logic [2:0] ADDR_STOP_DUR   = {mcr_pkg::REG_STOP_DUR, 2'b00};
    localparam int         CMD_LIMIT       = 255;
    localparam int         ITEMS_PER_PHASE = 172;
    localparam int         DRAIN_CYCLES    = 20;
    localparam int         IDLE_LIMIT      = 4000;

    typedef struct {
        logic              mode;
        logic signed [8:0] target;
        logic [31:0]       time_ms;
    } t_speed_update;

    typedef struct {
        logic [7:0]        fwd;
        logic [7:0]        rev;
        logic signed [8:0] cmd;
        logic              upd;
    } t_drive;

    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CHOKED} t_rx_style;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // target[8:0], time_ms[40:9], zero pad
    logic        s_axis_tuser;   // mode[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // forward_duty[7:0], reverse_duty[15:8],
                                 // command[24:16], updated[25], zero pad
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_speed_update update_q[$];     // updates waiting for the sender
    t_drive        drive_exp_q[$];  // predicted drive beats, oldest first

    // predictor copy of the block's registers and state
    int          ramp_ms;
    int          stop_ms;
    int          cmd_now;
    int          tgt_prev;
    int          step_now;
    logic [31:0] stamp_prev;

    int          err_cnt;
    int          idle_cycles;
    int          burst_left;
    int          gap_left;
    int          stall_left;
    t_rx_style   stall_style;
    logic        in_taken;

    motor_command_ramp_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Slew-limited ramp: one update in, one drive beat out.
    function automatic t_drive ramp_predict(input t_speed_update u);
        t_drive      r;
        int          goal;
        int          span;
        int          elapsed;
        int          diff;
        int          inc;
        int          next_cmd;
        logic [31:0] delta;
        goal = u.target;
        if (goal < -CMD_LIMIT) goal = -CMD_LIMIT;
        if (u.mode == MODE_STOP) begin
            goal = 0;
            span = stop_ms;
        end else begin
            span = ramp_ms;
        end
        if (span == 0) span = 1;
        elapsed = 1;
        r.upd = 1'b0;
        if (goal != cmd_now) begin
            // elapsed time only counts while chasing the same target
            if (goal == tgt_prev) begin
                delta   = u.time_ms - stamp_prev;
                elapsed = (delta > mcr_pkg::ELAPSED_MAX) ? int'(mcr_pkg::ELAPSED_MAX)
                                                         : int'(delta);
            end
            stamp_prev = u.time_ms;
            if (goal != tgt_prev) begin
                diff     = goal - cmd_now;
                step_now = diff / span;
                if (step_now == 0) step_now = (diff > 0) ? 1 : -1;
                tgt_prev = goal;
            end
            if (elapsed != 0) begin
                inc  = step_now * elapsed;
                diff = goal - cmd_now;
                // advance, or snap rather than overshoot
                if ((inc < 0 ? -inc : inc) < (diff < 0 ? -diff : diff)) next_cmd = cmd_now + inc;
                else next_cmd = goal;
                if (next_cmd > CMD_LIMIT) next_cmd = CMD_LIMIT;
                if (next_cmd < -CMD_LIMIT) next_cmd = -CMD_LIMIT;
                cmd_now = next_cmd;
                r.upd   = 1'b1;
            end
        end
        r.fwd = (cmd_now >= 0) ? 8'(cmd_now) : 8'd0;
        r.rev = (cmd_now < 0) ? 8'(-cmd_now) : 8'd0;
        r.cmd = 9'(cmd_now);
        return r;
    endfunction

    // Next time stamp of a well-formed sequence, with the odd jump.
    function automatic logic [31:0] next_stamp(input logic [31:0] t);
        case ($urandom_range(0, 19))
            0, 1:    return t;                            // no time passed
            2, 3:    return t + $urandom_range(16, 700);  // long gap, may saturate
            4:       return t - $urandom_range(1, 50);    // clock went backwards
            5:       return $urandom;                     // jump anywhere
            default: return t + $urandom_range(1, 15);
        endcase
    endfunction

    task automatic push_update(input logic mode, input int target, input logic [31:0] stamp);
        t_speed_update u;
        u.mode    = mode;
        u.target  = 9'(target);
        u.time_ms = stamp;
        update_q.push_back(u);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // setup then access; caller drops psel after the last write
    task automatic apb_write(input logic [2:0] addr, input int data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    // sender paused until every predicted beat has come back
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (update_q.size() != 0 || s_axis_tvalid || drive_exp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Update sender: bursts of random length with random gaps.
    always @(negedge i_clk) begin : sender
        t_speed_update u;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (update_q.size() != 0) begin
                u = update_q.pop_front();
                s_axis_tdata  <= {7'd0, u.time_ms, u.target};
                s_axis_tuser  <= u.mode;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side backpressure, switching among four styles at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_style = t_rx_style'($urandom_range(0, 3));
                stall_left  = $urandom_range(32, 256);
            end else begin
                stall_left--;
            end
            case (stall_style)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 7) != 0);
                default:   m_axis_tready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // Monitor: check drive beats, predict accepted updates, track registers.
    always @(posedge i_clk) begin : monitor
        t_drive        got;
        t_drive        want;
        t_speed_update u;
        if (!i_rst_n) begin
            ramp_ms     = int'(mcr_pkg::DUR_RESET);
            stop_ms     = int'(mcr_pkg::DUR_RESET);
            cmd_now     = 0;
            tgt_prev    = 0;
            step_now    = 0;
            stamp_prev  = '0;
            idle_cycles = 0;
            in_taken   <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;

            if (m_axis_tvalid && m_axis_tready) begin
                got.fwd = m_axis_tdata[7:0];
                got.rev = m_axis_tdata[15:8];
                got.cmd = m_axis_tdata[24:16];
                got.upd = m_axis_tdata[25];
                if (drive_exp_q.size() == 0) begin
                    $display("%0t: drive beat with none expected, expected nothing, got %h",
                             $time, m_axis_tdata);
                    err_cnt++;
                end else begin
                    want = drive_exp_q.pop_front();
                    check_field("forward_duty", want.fwd, got.fwd);
                    check_field("reverse_duty", want.rev, got.rev);
                    check_field("command", want.cmd, got.cmd);
                    check_field("updated", want.upd, got.upd);
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                u.mode    = s_axis_tuser;
                u.target  = s_axis_tdata[8:0];
                u.time_ms = s_axis_tdata[40:9];
                drive_exp_q.push_back(ramp_predict(u));
            end

            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == mcr_pkg::REG_STOP_DUR) stop_ms = pwdata[15:0];
                else ramp_ms = pwdata[15:0];
            end

            // watchdog on cycles with no beat and no register access
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] stamp;
        logic        mode;
        int          target;
        int          reps;
        int          quota;
        int          ramp_cfg [6];
        int          stop_cfg [6];

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        burst_left    = 1;
        gap_left      = 0;
        stall_left    = 0;
        stall_style   = RX_OPEN;
        err_cnt       = 0;
        idle_cycles   = 0;

        // extremes, zero duration (taken as one), a random pair, a fixed pair, back to reset values
        ramp_cfg = '{1, 65535, 0, $urandom_range(2, 400), 7, int'(mcr_pkg::DUR_RESET)};
        stop_cfg = '{65535, 1, 0, $urandom_range(2, 400), 300, int'(mcr_pkg::DUR_RESET)};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed pass on reset durations
        push_update(MODE_SPEED, 255, 32'd0);           // new target, one ms
        push_update(MODE_SPEED, 255, 32'd10);          // same target, 10 ms
        push_update(MODE_SPEED, 255, 32'd10);          // zero elapsed, holds
        push_update(MODE_SPEED, 255, 32'd610);         // elapsed saturates, snaps
        push_update(MODE_SPEED, 255, 32'd700);         // at target already
        push_update(MODE_SPEED, -256, 32'hFFFF_FFF0);  // most negative saturates
        push_update(MODE_SPEED, -255, 32'd5);          // stamp wraps
        push_update(MODE_STOP, 200, 32'd6);            // stop ignores target
        push_update(MODE_STOP, 0, 32'd6);
        push_update(MODE_STOP, -100, 32'd2000);
        push_update(MODE_STOP, 37, 32'd2001);
        push_update(MODE_SPEED, 1, 32'd2002);          // step rounds up to one
        push_update(MODE_SPEED, -1, 32'd2003);
        push_update(MODE_SPEED, -1, 32'd2004);
        push_update(MODE_SPEED, 0, 32'd2005);
        push_update(MODE_SPEED, 0, 32'd2006);
        push_update(MODE_SPEED, 100, 32'd3000);
        push_update(MODE_SPEED, 100, 32'd2000);        // stamp went backwards
        push_update(MODE_SPEED, -255, 32'd2001);
        push_update(MODE_SPEED, -255, 32'hFFFF_FFFF);
        push_update(MODE_STOP, 255, 32'd0);
        push_update(MODE_SPEED, 255, 32'd1);

        foreach (ramp_cfg[p]) begin
            wait_idle();
            apb_write(ADDR_RAMP_DUR, ramp_cfg[p]);
            apb_write(ADDR_STOP_DUR, stop_cfg[p]);
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;

            // mostly held targets with advancing stamps, some noise
            stamp = (p % 2 == 1) ? 32'hFFFF_FE00 + $urandom_range(0, 255) : $urandom;
            quota = ITEMS_PER_PHASE;
            while (quota > 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_update(1'($urandom_range(0, 1)), $urandom_range(0, 511) - 256,
                                $urandom);
                    quota--;
                end else begin
                    mode = ($urandom_range(0, 3) == 0) ? MODE_STOP : MODE_SPEED;
                    case ($urandom_range(0, 4))
                        0:       target = 255;
                        1:       target = -255 - $urandom_range(0, 1);
                        default: target = $urandom_range(0, 510) - 255;
                    endcase
                    reps = $urandom_range(1, 12);
                    repeat (reps) begin
                        stamp = next_stamp(stamp);
                        push_update(mode, (mode == MODE_STOP) ?
                                    $urandom_range(0, 511) - 256 : target, stamp);
                        quota--;
                    end
                end
            end
        end

        wait_idle();
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
